### rtl/qmr_pkg.sv
// shared constants and term sign table for the quaternion multiply/rotate unit
// no dependencies; imported by qmr_sum and the top level
package qmr_pkg;

  // default component format, signed Q2.14
  localparam int unsigned COMPONENT_WIDTH_DEF = 16;
  localparam int unsigned FRACTION_BITS_DEF   = 14;

  // extra integer bits kept by the rotate intermediate A*(0,v)
  localparam int unsigned ROT_GUARD = 4;

  // action codes
  localparam logic ACT_MUL = 1'b0;
  localparam logic ACT_ROT = 1'b1;

  // hamilton product: component k sums p[i]*q[i^k]; bit i set means subtract
  localparam logic [3:0] HAM_NEG [4] = '{4'b1110, 4'b1000, 4'b0010, 4'b0100};

  // sign of one term; conj flips every term whose q index is a vector part
  function automatic logic term_neg(input logic [1:0] k, input logic [1:0] i,
                                    input logic conj);
    logic vec;
    vec = ((i ^ k) != 2'd0);
    return HAM_NEG[k][i] ^ (conj & vec);
  endfunction

endpackage

### rtl/qmr_mul.sv
// product stage: up to sixteen operand products of one hamilton pass, registered
// depends on nothing but the enable from the pipeline control in the top level
module qmr_mul #(
  parameter int unsigned XW    = 16,
  parameter int unsigned YW    = 16,
  parameter int unsigned FIRST = 0
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [XW-1:0]     x_i    [4],
  input  logic signed [YW-1:0]     y_i    [4],
  output logic signed [XW+YW-1:0]  prod_o [4][4]
);

  localparam int unsigned PW = XW + YW;

  // component k, term i: x[i] * y[i^k]; components below FIRST are not built
  for (genvar k = 0; k < 4; k++) begin : g_comp
    for (genvar i = 0; i < 4; i++) begin : g_term
      if (k < FIRST) begin : g_skip
        assign prod_o[k][i] = '0;
      end else begin : g_prod
        logic signed [PW-1:0] p_q;
        always_ff @(posedge clk_i) begin
          if (en_i) begin
            p_q <= x_i[i] * y_i[i ^ k];
          end
        end
        assign prod_o[k][i] = p_q;
      end
    end
  end

endmodule

### rtl/qmr_sum.sv
// sum stage: signed sum of four products per component plus the rounding half
// uses qmr_pkg for the term sign table
module qmr_sum #(
  parameter int unsigned PW   = 32,
  parameter int unsigned FB   = 14,
  parameter bit          CONJ = 1'b0
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic signed [PW-1:0]  prod_i [4][4],
  output logic signed [PW+2:0]  sum_o  [4]
);

  import qmr_pkg::*;

  localparam int unsigned SW = PW + 3;
  localparam logic signed [SW-1:0] ROUND = SW'(1) << (FB - 1);

  logic signed [SW-1:0] sum_d [4];
  logic signed [SW-1:0] sum_q [4];

  // add or subtract each term per the hamilton signs
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sum_d[k] = ROUND;
      for (int i = 0; i < 4; i++) begin
        if (term_neg(2'(k), 2'(i), CONJ)) begin
          sum_d[k] = sum_d[k] - SW'(prod_i[k][i]);
        end else begin
          sum_d[k] = sum_d[k] + SW'(prod_i[k][i]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

### rtl/qmr_sat.sv
// saturate stage: drop the fraction bits, then clip to the wide or narrow range
// no package use; narrow_i picks the narrow range per item
module qmr_sat #(
  parameter int unsigned SW = 35,
  parameter int unsigned FB = 14,
  parameter int unsigned OW = 20,
  parameter int unsigned NW = 16
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic                  narrow_i,
  input  logic signed [SW-1:0]  sum_i  [4],
  output logic signed [OW-1:0]  res_o  [4],
  output logic [3:0]            clip_o
);

  localparam int unsigned CW = ((SW > OW) ? SW : OW) + 1;

  localparam logic signed [CW-1:0] WIDE_MAX = {{(CW-OW+1){1'b0}}, {(OW-1){1'b1}}};
  localparam logic signed [CW-1:0] WIDE_MIN = {{(CW-OW+1){1'b1}}, {(OW-1){1'b0}}};
  localparam logic signed [CW-1:0] NARR_MAX = {{(CW-NW+1){1'b0}}, {(NW-1){1'b1}}};
  localparam logic signed [CW-1:0] NARR_MIN = {{(CW-NW+1){1'b1}}, {(NW-1){1'b0}}};

  logic signed [SW-1:0] shr   [4];
  logic signed [CW-1:0] ext   [4];
  logic signed [CW-1:0] hi_lim;
  logic signed [CW-1:0] lo_lim;
  logic signed [OW-1:0] res_d [4];
  logic signed [OW-1:0] res_q [4];
  logic [3:0]           clip_d;
  logic [3:0]           clip_q;

  // arithmetic shift, then clip against the selected limits
  always_comb begin
    hi_lim = narrow_i ? NARR_MAX : WIDE_MAX;
    lo_lim = narrow_i ? NARR_MIN : WIDE_MIN;
    for (int k = 0; k < 4; k++) begin
      shr[k] = sum_i[k] >>> FB;
      ext[k] = {{(CW-SW){shr[k][SW-1]}}, shr[k]};
      if (ext[k] > hi_lim) begin
        res_d[k]  = hi_lim[OW-1:0];
        clip_d[k] = 1'b1;
      end else if (ext[k] < lo_lim) begin
        res_d[k]  = lo_lim[OW-1:0];
        clip_d[k] = 1'b1;
      end else begin
        res_d[k]  = ext[k][OW-1:0];
        clip_d[k] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q  <= res_d;
      clip_q <= clip_d;
    end
  end

  assign res_o  = res_q;
  assign clip_o = clip_q;

endmodule

### rtl/quaternion_multiply_rotate.sv
// Quaternion multiply/rotate unit in signed fixed point (Q2.14 by default).
// Action 0 returns the Hamilton product A*B; action 1 rotates (b_x, b_y, b_z) by A
// as A*(0,v)*conj(A), with res_w forced to 0. Each component is an exact sum of
// four products, rounded to nearest (ties up) and saturated; saturated_o flags any
// clip, including clipping of the rotate intermediate, which keeps four extra
// integer bits. The unit takes one transfer every clock unless the output stalls
// and returns its result through two passes of product, sum and saturate register
// stages. Valid bits travel with the data and each stage only stalls when full, so
// bubbles collapse; the input keeps taking transfers while any stage is empty.
// depends on qmr_pkg, qmr_mul, qmr_sum and qmr_sat
module quaternion_multiply_rotate #(
  parameter int unsigned COMPONENT_WIDTH = qmr_pkg::COMPONENT_WIDTH_DEF,
  parameter int unsigned FRACTION_BITS   = qmr_pkg::FRACTION_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              action_i,
  input  logic signed [COMPONENT_WIDTH-1:0] a_w_i,
  input  logic signed [COMPONENT_WIDTH-1:0] a_x_i,
  input  logic signed [COMPONENT_WIDTH-1:0] a_y_i,
  input  logic signed [COMPONENT_WIDTH-1:0] a_z_i,
  input  logic signed [COMPONENT_WIDTH-1:0] b_w_i,
  input  logic signed [COMPONENT_WIDTH-1:0] b_x_i,
  input  logic signed [COMPONENT_WIDTH-1:0] b_y_i,
  input  logic signed [COMPONENT_WIDTH-1:0] b_z_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [COMPONENT_WIDTH-1:0] res_w_o,
  output logic signed [COMPONENT_WIDTH-1:0] res_x_o,
  output logic signed [COMPONENT_WIDTH-1:0] res_y_o,
  output logic signed [COMPONENT_WIDTH-1:0] res_z_o,
  output logic                              saturated_o
);

  import qmr_pkg::*;

  localparam int unsigned W   = COMPONENT_WIDTH;
  localparam int unsigned TW  = W + ROT_GUARD;
  localparam int unsigned P1W = 2 * W;
  localparam int unsigned P2W = TW + W;

  // pipeline control: stage k loads when empty or when its successor loads
  logic [5:0] vld_q;
  logic [5:0] vld_d;
  logic [5:0] en;

  always_comb begin
    en[5] = !vld_q[5] || out_ready_i;
    en[4] = !vld_q[4] || en[5];
    en[3] = !vld_q[3] || en[4];
    en[2] = !vld_q[2] || en[3];
    en[1] = !vld_q[1] || en[2];
    en[0] = !vld_q[0] || en[1];
  end

  assign vld_d = (en & {vld_q[4:0], in_valid_i}) | (~en & vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[5];

  // operands; the rotate pass uses (0, v)
  logic signed [W-1:0] a_in [4];
  logic signed [W-1:0] b_in [4];

  assign a_in[0] = a_w_i;
  assign a_in[1] = a_x_i;
  assign a_in[2] = a_y_i;
  assign a_in[3] = a_z_i;
  assign b_in[0] = (action_i == ACT_ROT) ? '0 : b_w_i;
  assign b_in[1] = b_x_i;
  assign b_in[2] = b_y_i;
  assign b_in[3] = b_z_i;

  // first pass: A*B, or A*(0,v) kept at the wider intermediate width
  logic signed [P1W-1:0] prod1 [4][4];
  logic signed [P1W+2:0] sum1  [4];
  logic signed [TW-1:0]  t1    [4];
  logic [3:0]            clip1;

  qmr_mul #(.XW(W), .YW(W), .FIRST(0)) u_mul1 (
    .clk_i  (clk_i),
    .en_i   (en[0]),
    .x_i    (a_in),
    .y_i    (b_in),
    .prod_o (prod1)
  );

  qmr_sum #(.PW(P1W), .FB(FRACTION_BITS), .CONJ(1'b0)) u_sum1 (
    .clk_i  (clk_i),
    .en_i   (en[1]),
    .prod_i (prod1),
    .sum_o  (sum1)
  );

  // side data for the second pass and the final select
  logic [5:0]          act_q;
  logic signed [W-1:0] a1_q [4];
  logic signed [W-1:0] a2_q [4];
  logic signed [W-1:0] a3_q [4];
  logic signed [W-1:0] t4_q [4];
  logic signed [W-1:0] t5_q [4];
  logic signed [W-1:0] t6_q [4];
  logic                c4_q;
  logic                c5_q;
  logic                c6_q;

  qmr_sat #(.SW(P1W + 3), .FB(FRACTION_BITS), .OW(TW), .NW(W)) u_sat1 (
    .clk_i    (clk_i),
    .en_i     (en[2]),
    .narrow_i (act_q[1] == ACT_MUL),
    .sum_i    (sum1),
    .res_o    (t1),
    .clip_o   (clip1)
  );

  // second pass: T*conj(A), scalar part not built
  logic signed [P2W-1:0] prod2 [4][4];
  logic signed [P2W+2:0] sum2  [4];
  logic signed [W-1:0]   r2    [4];
  logic [3:0]            clip2;

  qmr_mul #(.XW(TW), .YW(W), .FIRST(1)) u_mul2 (
    .clk_i  (clk_i),
    .en_i   (en[3]),
    .x_i    (t1),
    .y_i    (a3_q),
    .prod_o (prod2)
  );

  qmr_sum #(.PW(P2W), .FB(FRACTION_BITS), .CONJ(1'b1)) u_sum2 (
    .clk_i  (clk_i),
    .en_i   (en[4]),
    .prod_i (prod2),
    .sum_o  (sum2)
  );

  qmr_sat #(.SW(P2W + 3), .FB(FRACTION_BITS), .OW(W), .NW(W)) u_sat2 (
    .clk_i    (clk_i),
    .en_i     (en[5]),
    .narrow_i (1'b1),
    .sum_i    (sum2),
    .res_o    (r2),
    .clip_o   (clip2)
  );

  // delay line for action, A and the first-pass result
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      act_q[0] <= action_i;
      a1_q     <= a_in;
    end
    if (en[1]) begin
      act_q[1] <= act_q[0];
      a2_q     <= a1_q;
    end
    if (en[2]) begin
      act_q[2] <= act_q[1];
      a3_q     <= a2_q;
    end
    if (en[3]) begin
      act_q[3] <= act_q[2];
      for (int k = 0; k < 4; k++) begin
        t4_q[k] <= t1[k][W-1:0];
      end
      c4_q     <= |clip1;
    end
    if (en[4]) begin
      act_q[4] <= act_q[3];
      t5_q     <= t4_q;
      c5_q     <= c4_q;
    end
    if (en[5]) begin
      act_q[5] <= act_q[4];
      t6_q     <= t5_q;
      c6_q     <= c5_q;
    end
  end

  // result select: multiply takes the first pass, rotate the second
  logic rot_out;
  assign rot_out = (act_q[5] == ACT_ROT);

  assign res_w_o     = rot_out ? r2[0] : t6_q[0];
  assign res_x_o     = rot_out ? r2[1] : t6_q[1];
  assign res_y_o     = rot_out ? r2[2] : t6_q[2];
  assign res_z_o     = rot_out ? r2[3] : t6_q[3];
  assign saturated_o = c6_q | (rot_out & (|clip2));

  // rotate results never carry a scalar part
  a_rot_w_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && rot_out |-> res_w_o == '0)
    else $error("rotate result with nonzero scalar part");

  // input only backs up when every stage is full and the output is stalled
  a_full_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (&vld_q) && !out_ready_i)
    else $error("input stalled with a bubble in the pipeline");

  // a stalled middle stage keeps its item
  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[2] && !en[2] |=> vld_q[2])
    else $error("stalled stage dropped its item");

endmodule
